/* src/assert_macros.svh */
// assertion helpers included by the filter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/iirdf2t_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iirdf2t_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MAX_ORDER_DEF   = 3;

    localparam int COEF_BITS   = 24;
    localparam int COEF_FRAC   = 21;
    // state is the sample width plus this many bits
    localparam int STATE_EXTRA = 24;
    // accumulator keeps two guard bits over the state
    localparam int ACC_EXTRA   = STATE_EXTRA + 2;

    localparam int NUM_B   = 4;
    localparam int NUM_A   = 3;
    localparam int TAPS_W  = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic signed [COEF_BITS-1:0] B0_RESET   = 24'sd2097152;
    localparam logic [TAPS_W-1:0]           TAPS_RESET = 3'd1;

    typedef enum logic [2:0] {
        REG_B0   = 3'd0,
        REG_B1   = 3'd1,
        REG_B2   = 3'd2,
        REG_B3   = 3'd3,
        REG_A1   = 3'd4,
        REG_A2   = 3'd5,
        REG_A3   = 3'd6,
        REG_TAPS = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Y_MUL,
        ST_Y_ADD,
        ST_Y_RND,
        ST_T_MUL,
        ST_T_ADD,
        ST_T_SUB,
        ST_T_WR,
        ST_DONE
    } fsm_state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

endpackage

`default_nettype wire

/* src/iir_direct_form2_transposed_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                   | direction
// s_ (in)   | s_valid s_ready s_sample_in             | sample word into the filter
// m_ (out)  | m_valid m_ready m_filtered_out          | filtered word, saturated,
//           | m_saturated_flag                        | with clip flag
// apb       | psel penable pwrite paddr pwdata prdata | coefficient and tap count
//           | pready                                  | registers, 4-byte stride
//
// after acceptance the sequencer works through y_mul, y_add and y_rnd for the output,
// then per delay tap t_mul, t_add, t_sub, t_wr (multiply b, add delay, subtract a*y,
// write back), then done and idle; no new word is taken until it is back in idle
// s_ready is high only while the sequencer is idle and out of reset
// a finished word moves to the output register; the next one waits in done while unread
// aresetn is synchronous: delays clear to zero, coefficients to b0 = 1.0, one tap

module iir_direct_form2_transposed_core #(
    parameter int MAX_ORDER   = iirdf2t_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_BITS = iirdf2t_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]    s_sample_in,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]         m_filtered_out,
    output logic                                  m_saturated_flag,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [iirdf2t_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [iirdf2t_pkg::DATA_W-1:0]   pwdata,
    output logic [iirdf2t_pkg::DATA_W-1:0]        prdata,
    output logic                                  pready
);

    `include "assert_macros.svh"

    localparam int COEF_BITS  = iirdf2t_pkg::COEF_BITS;
    localparam int COEF_FRAC  = iirdf2t_pkg::COEF_FRAC;
    localparam int TAPS_W     = iirdf2t_pkg::TAPS_W;
    localparam int DATA_W     = iirdf2t_pkg::DATA_W;
    localparam int ADDR_W     = iirdf2t_pkg::ADDR_W;
    localparam int STATE_BITS = SAMPLE_BITS + iirdf2t_pkg::STATE_EXTRA;
    localparam int ACC_W      = SAMPLE_BITS + iirdf2t_pkg::ACC_EXTRA;
    localparam int YW_W       = ACC_W - COEF_FRAC;
    localparam int MAX_TAPS   = MAX_ORDER + 1;
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);
    localparam int IDX_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int BSEL_W     = $clog2(iirdf2t_pkg::NUM_B);
    localparam int ASEL_W     = $clog2(iirdf2t_pkg::NUM_A);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [STATE_BITS-1:0]  STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0]  STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic [ACC_W-1:0]              RND_HALF   = ACC_W'(1) << (COEF_FRAC - 1);

    // sequencer and control
    iirdf2t_pkg::fsm_state_t state_reg;
    iirdf2t_pkg::fsm_state_t state_next;
    iirdf2t_pkg::mac_ctrl_t  mac_ctrl;

    logic [ORD_W-1:0] order_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [ORD_W-1:0] tap_num;
    logic             last_tap;

    // configuration registers
    logic signed [COEF_BITS-1:0] coef_b_reg [iirdf2t_pkg::NUM_B];
    logic signed [COEF_BITS-1:0] coef_a_reg [iirdf2t_pkg::NUM_A];
    logic [TAPS_W-1:0]           taps_reg;

    // delay line
    logic signed [STATE_BITS-1:0] z_reg [MAX_ORDER];

    // working words
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          hit_reg;

    // output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_filtered_out_reg;
    logic                          m_saturated_flag_reg;
    logic                          out_free;

    // datapath signals
    logic [TAPS_W-1:0]             taps_eff;
    logic [ORD_W-1:0]              order_calc;
    logic                          cfg_wr;
    iirdf2t_pkg::reg_idx_t         cfg_idx;
    logic                          use_a;
    logic                          use_y;
    logic [BSEL_W-1:0]             b_sel;
    logic [ASEL_W-1:0]             a_sel;
    logic signed [COEF_BITS-1:0]   mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_operand;
    logic [ORD_W-1:0]              z_rd_num;
    logic signed [STATE_BITS-1:0]  z_rd;
    logic signed [ACC_W-1:0]       mac_addend;
    logic signed [ACC_W-1:0]       acc;
    logic [ACC_W-1:0]              rnd_sum;
    logic signed [YW_W-1:0]        y_wide;
    logic                          y_fits;
    logic signed [SAMPLE_BITS-1:0] y_clip;
    logic                          y_hit;
    logic                          z_fits;
    logic signed [STATE_BITS-1:0]  z_clip;

    // apb port: writes in the access phase, reads straight from the registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = iirdf2t_pkg::reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb begin
        unique case (cfg_idx)
            iirdf2t_pkg::REG_B0:   prdata = DATA_W'($unsigned(coef_b_reg[0]));
            iirdf2t_pkg::REG_B1:   prdata = DATA_W'($unsigned(coef_b_reg[1]));
            iirdf2t_pkg::REG_B2:   prdata = DATA_W'($unsigned(coef_b_reg[2]));
            iirdf2t_pkg::REG_B3:   prdata = DATA_W'($unsigned(coef_b_reg[3]));
            iirdf2t_pkg::REG_A1:   prdata = DATA_W'($unsigned(coef_a_reg[0]));
            iirdf2t_pkg::REG_A2:   prdata = DATA_W'($unsigned(coef_a_reg[1]));
            iirdf2t_pkg::REG_A3:   prdata = DATA_W'($unsigned(coef_a_reg[2]));
            iirdf2t_pkg::REG_TAPS: prdata = DATA_W'(taps_reg);
            default:               prdata = '0;
        endcase
    end

    // zero taps act as one, too many clamp to the built order
    always_comb begin
        priority if (taps_reg == '0) begin
            taps_eff = TAPS_W'(1);
        end else if (taps_reg > TAPS_W'(MAX_TAPS)) begin
            taps_eff = TAPS_W'(MAX_TAPS);
        end else begin
            taps_eff = taps_reg;
        end
    end

    assign order_calc = ORD_W'(taps_eff - TAPS_W'(1));

    // tap_num is the delay index plus one, i.e. the coefficient pair in use
    assign tap_num  = ORD_W'(idx_reg) + ORD_W'(1);
    assign last_tap = (tap_num == order_reg);
    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_op = iirdf2t_pkg::ACC_HOLD;
        use_a           = 1'b0;
        use_y           = 1'b0;
        mac_addend      = '0;
        z_rd_num        = tap_num;

        unique case (state_reg)
            iirdf2t_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = iirdf2t_pkg::ST_Y_MUL;
                end
            end
            iirdf2t_pkg::ST_Y_MUL: begin
                // b0 * x
                mac_ctrl.mul_en = 1'b1;
                state_next      = iirdf2t_pkg::ST_Y_ADD;
            end
            iirdf2t_pkg::ST_Y_ADD: begin
                // z0 + b0 * x, z0 left out at order zero
                z_rd_num        = '0;
                mac_ctrl.acc_op = iirdf2t_pkg::ACC_LOAD;
                if (order_reg != '0) begin
                    mac_addend = ACC_W'(z_rd);
                end
                state_next = iirdf2t_pkg::ST_Y_RND;
            end
            iirdf2t_pkg::ST_Y_RND: begin
                if (order_reg != '0) begin
                    state_next = iirdf2t_pkg::ST_T_MUL;
                end else begin
                    state_next = iirdf2t_pkg::ST_DONE;
                end
            end
            iirdf2t_pkg::ST_T_MUL: begin
                // b[k] * x
                mac_ctrl.mul_en = 1'b1;
                state_next      = iirdf2t_pkg::ST_T_ADD;
            end
            iirdf2t_pkg::ST_T_ADD: begin
                // next delay plus b[k] * x, while a[k] * y goes into the multiplier
                mac_ctrl.acc_op = iirdf2t_pkg::ACC_LOAD;
                mac_ctrl.mul_en = 1'b1;
                use_a           = 1'b1;
                use_y           = 1'b1;
                if (!last_tap) begin
                    mac_addend = ACC_W'(z_rd);
                end
                state_next = iirdf2t_pkg::ST_T_SUB;
            end
            iirdf2t_pkg::ST_T_SUB: begin
                mac_ctrl.acc_op = iirdf2t_pkg::ACC_SUB;
                state_next      = iirdf2t_pkg::ST_T_WR;
            end
            iirdf2t_pkg::ST_T_WR: begin
                if (last_tap) begin
                    state_next = iirdf2t_pkg::ST_DONE;
                end else begin
                    state_next = iirdf2t_pkg::ST_T_MUL;
                end
            end
            iirdf2t_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = iirdf2t_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = iirdf2t_pkg::ST_IDLE;
            end
        endcase
    end

    // operand selection for the shared multiplier
    assign b_sel       = (state_reg == iirdf2t_pkg::ST_T_MUL) ? BSEL_W'(tap_num) : '0;
    assign a_sel       = ASEL_W'(idx_reg);
    assign mul_coef    = use_a ? coef_a_reg[a_sel] : coef_b_reg[b_sel];
    assign mul_operand = use_y ? y_reg : x_reg;

    // single read port on the delay line
    always_comb begin
        z_rd = '0;
        if (z_rd_num < ORD_W'(MAX_ORDER)) begin
            z_rd = z_reg[IDX_W'(z_rd_num)];
        end
    end

    iirdf2t_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .coef    (mul_coef),
        .operand (mul_operand),
        .addend  (mac_addend),
        .acc     (acc)
    );

    // round half up, drop the fraction, clip to the sample range
    assign rnd_sum = $unsigned(acc) + RND_HALF;
    assign y_wide  = $signed(rnd_sum[ACC_W-1:COEF_FRAC]);
    assign y_fits  = (y_wide[YW_W-1:SAMPLE_BITS-1] == '0) ||
                     (y_wide[YW_W-1:SAMPLE_BITS-1] == '1);
    assign y_hit   = !y_fits;
    assign y_clip  = y_fits ? y_wide[SAMPLE_BITS-1:0] :
                     (y_wide[YW_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

    // new delay value clips silently to the state range
    assign z_fits = (acc[ACC_W-1:STATE_BITS-1] == '0) ||
                    (acc[ACC_W-1:STATE_BITS-1] == '1);
    assign z_clip = z_fits ? acc[STATE_BITS-1:0] :
                    (acc[ACC_W-1] ? STATE_MIN : STATE_MAX);

    // control, configuration and delay state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= iirdf2t_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            order_reg     <= '0;
            idx_reg       <= '0;
            coef_b_reg[0] <= iirdf2t_pkg::B0_RESET;
            coef_b_reg[1] <= '0;
            coef_b_reg[2] <= '0;
            coef_b_reg[3] <= '0;
            coef_a_reg[0] <= '0;
            coef_a_reg[1] <= '0;
            coef_a_reg[2] <= '0;
            taps_reg      <= iirdf2t_pkg::TAPS_RESET;
            for (int i = 0; i < MAX_ORDER; i++) begin
                z_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                unique case (cfg_idx)
                    iirdf2t_pkg::REG_B0:   coef_b_reg[0] <= pwdata[COEF_BITS-1:0];
                    iirdf2t_pkg::REG_B1:   coef_b_reg[1] <= pwdata[COEF_BITS-1:0];
                    iirdf2t_pkg::REG_B2:   coef_b_reg[2] <= pwdata[COEF_BITS-1:0];
                    iirdf2t_pkg::REG_B3:   coef_b_reg[3] <= pwdata[COEF_BITS-1:0];
                    iirdf2t_pkg::REG_A1:   coef_a_reg[0] <= pwdata[COEF_BITS-1:0];
                    iirdf2t_pkg::REG_A2:   coef_a_reg[1] <= pwdata[COEF_BITS-1:0];
                    iirdf2t_pkg::REG_A3:   coef_a_reg[2] <= pwdata[COEF_BITS-1:0];
                    iirdf2t_pkg::REG_TAPS: taps_reg      <= pwdata[TAPS_W-1:0];
                    default:               taps_reg      <= taps_reg;
                endcase
            end

            if (s_valid && s_ready) begin
                order_reg <= order_calc;
                idx_reg   <= '0;
            end

            // delays update in rising order, so z[k] is still the old value here
            if (state_reg == iirdf2t_pkg::ST_T_WR) begin
                z_reg[idx_reg] <= z_clip;
                idx_reg        <= idx_reg + IDX_W'(1);
            end

            // a new word replaces the one leaving in the same cycle
            if (state_reg == iirdf2t_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == iirdf2t_pkg::ST_Y_RND) begin
            y_reg   <= y_clip;
            hit_reg <= y_hit;
        end
        if (state_reg == iirdf2t_pkg::ST_DONE && out_free) begin
            m_filtered_out_reg   <= y_reg;
            m_saturated_flag_reg <= hit_reg;
        end
    end

    assign s_ready          = aresetn && (state_reg == iirdf2t_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_filtered_out   = m_filtered_out_reg;
    assign m_saturated_flag = m_saturated_flag_reg;

    // checks
    `ASSERT_NEXT(a_accept_starts_work, aclk, aresetn, s_valid && s_ready,
        state_reg == iirdf2t_pkg::ST_Y_MUL, "accepted word did not start the sequencer")

    `ASSERT_IMPL(a_tap_in_order, aclk, aresetn,
        (state_reg == iirdf2t_pkg::ST_T_MUL || state_reg == iirdf2t_pkg::ST_T_ADD ||
         state_reg == iirdf2t_pkg::ST_T_SUB || state_reg == iirdf2t_pkg::ST_T_WR),
        (order_reg != '0) && (tap_num <= order_reg), "delay tap beyond the filter order")

    `ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        state_reg == iirdf2t_pkg::ST_DONE && out_free, m_valid, "finished word not presented")

    `ASSERT_IMPL(a_clip_at_rail, aclk, aresetn, m_valid && m_saturated_flag,
        m_filtered_out == SAMPLE_MAX || m_filtered_out == SAMPLE_MIN,
        "clip flag set on a value inside the range")

endmodule

`default_nettype wire

/* src/iirdf2t_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

// shared multiplier with registered product and accumulator
module iirdf2t_mac #(
    parameter int SAMPLE_BITS = iirdf2t_pkg::SAMPLE_BITS_DEF,
    localparam int ACC_W      = SAMPLE_BITS + iirdf2t_pkg::ACC_EXTRA
) (
    input  wire logic                                    aclk,
    input  wire iirdf2t_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [iirdf2t_pkg::COEF_BITS-1:0] coef,
    input  wire logic signed [SAMPLE_BITS-1:0]           operand,
    input  wire logic signed [ACC_W-1:0]                 addend,
    output logic signed [ACC_W-1:0]                      acc
);

    localparam int PROD_W = iirdf2t_pkg::COEF_BITS + SAMPLE_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod_next = coef * operand;

    always_comb begin
        unique case (ctrl.acc_op)
            iirdf2t_pkg::ACC_LOAD: acc_next = addend + ACC_W'(prod_reg);
            iirdf2t_pkg::ACC_SUB:  acc_next = acc_reg - ACC_W'(prod_reg);
            default:               acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_W  = iirdf2t_pkg::SAMPLE_BITS_DEF;
    localparam int MAX_ORD   = iirdf2t_pkg::MAX_ORDER_DEF;
    localparam int STATE_W   = SAMPLE_W + iirdf2t_pkg::STATE_EXTRA;
    localparam int COEF_BITS = iirdf2t_pkg::COEF_BITS;
    localparam int COEF_FRAC = iirdf2t_pkg::COEF_FRAC;
    localparam int DATA_W    = iirdf2t_pkg::DATA_W;
    localparam int ADDR_W    = iirdf2t_pkg::ADDR_W;
    localparam int TAPS_W    = iirdf2t_pkg::TAPS_W;
    localparam int NUM_B     = iirdf2t_pkg::NUM_B;
    localparam int NUM_A     = iirdf2t_pkg::NUM_A;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint STATE_MAX  = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN  = -STATE_MAX - 1;
    // half an output lsb in accumulator units, for round half up
    localparam longint HALF_LSB   = longint'(1) <<< (COEF_FRAC - 1);

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;

    localparam coef_t COEF_ONE = coef_t'(1 << COEF_FRAC);
    localparam coef_t COEF_MAX = coef_t'((1 << (COEF_BITS - 1)) - 1);
    localparam coef_t COEF_MIN = coef_t'(-(1 << (COEF_BITS - 1)));

    localparam int NUM_SEGMENTS  = 12;
    localparam int SEGMENT_WORDS = 150;
    localparam int LONG_HOLD     = 400;
    // a bit over two words at the highest order
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 5_000_000;

    // one filtered word as it leaves the block
    typedef struct {
        sample_t y;
        bit      clip;
    } filtered_t;

    // a word sent with its output written out by hand, or left to the model
    typedef struct {
        bit        fixed;
        filtered_t out;
    } preset_t;

    typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        iirdf2t_pkg::reg_idx_t idx;
        logic [DATA_W-1:0]     data;
        sample_t               x;
        bit                    fixed;
        sample_t               y;
        bit                    clip;
    } plan_row_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;

    logic              s_valid     = 1'b0;
    logic              s_ready;
    sample_t           s_sample_in = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    sample_t           m_filtered_out;
    logic              m_saturated_flag;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // filter model: coefficient copies and delay line
    coef_t             model_b [NUM_B];
    coef_t             model_a [NUM_A];
    logic [TAPS_W-1:0] model_taps;
    longint            model_z [MAX_ORD];

    filtered_t filtered_q [$];
    preset_t   preset_q [$];
    plan_row_t plan_q [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int err_count    = 0;

    always #5 aclk = ~aclk;

    iir_direct_form2_transposed_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_in      (s_sample_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_out   (m_filtered_out),
        .m_saturated_flag (m_saturated_flag),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // one sample through the transposed direct form ii model
    function automatic filtered_t run_filter(input sample_t x);
        filtered_t res;
        int unsigned taps;
        int order;
        longint acc, y, nz;
        taps = model_taps;
        // zero taps behaves as one, anything past the top clamps
        if (taps == 0) taps = 1;
        if (taps > MAX_ORD + 1) taps = MAX_ORD + 1;
        order = taps - 1;
        acc = longint'(model_b[0]) * longint'(x);
        if (order > 0) acc += model_z[0];
        y = (acc + HALF_LSB) >>> COEF_FRAC;
        res.clip = 1'b0;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
            res.clip = 1'b1;
        end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
            res.clip = 1'b1;
        end
        // clipped y is what feeds back; old z[i+1] is read before it is replaced
        for (int i = 0; i < order; i++) begin
            nz = longint'(model_b[i + 1]) * longint'(x) - longint'(model_a[i]) * y;
            if (i + 1 < order) nz += model_z[i + 1];
            // delays saturate silently
            if (nz > STATE_MAX) nz = STATE_MAX;
            else if (nz < STATE_MIN) nz = STATE_MIN;
            model_z[i] = nz;
        end
        res.y = sample_t'(y);
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input longint want,
                                          input longint got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function automatic void plan_write(input iirdf2t_pkg::reg_idx_t idx,
                                       input logic [DATA_W-1:0] data);
        plan_row_t row;
        row = '{ROW_WRITE, idx, data, '0, 1'b0, '0, 1'b0};
        plan_q.push_back(row);
    endfunction

    function automatic void plan_sample(input sample_t x, input bit fixed, input sample_t y,
                                        input bit clip);
        plan_row_t row;
        row = '{ROW_SAMPLE, iirdf2t_pkg::REG_B0, '0, x, fixed, y, clip};
        plan_q.push_back(row);
    endfunction

    function automatic sample_t pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            case ($urandom_range(4))
                0:       return sample_t'(SAMPLE_MAX);
                1:       return sample_t'(SAMPLE_MIN);
                2:       return '0;
                3:       return sample_t'(1);
                default: return sample_t'(-1);
            endcase
        end
        // small audio-like levels keep stable filters out of clipping
        if (roll < 45) return sample_t'(int'($urandom_range(8191)) - 4096);
        return sample_t'($urandom);
    endfunction

    // style 0 keeps the feedback small enough to stay stable
    function automatic coef_t pick_coef(input int unsigned style, input bit feedback);
        int lim;
        lim = feedback ? (1 << (COEF_FRAC - 2)) : (1 << COEF_FRAC);
        case (style)
            0: return coef_t'(int'($urandom_range(2 * lim)) - lim);
            1: return coef_t'($urandom);
            2: begin
                case ($urandom_range(3))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    default: return COEF_ONE;
                endcase
            end
            default: return coef_t'(int'($urandom_range(4 * lim)) - 2 * lim);
        endcase
    endfunction

    // apb write, setup then access, then back to idle; model follows the access
    task automatic reg_write(input iirdf2t_pkg::reg_idx_t idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            iirdf2t_pkg::REG_B0, iirdf2t_pkg::REG_B1,
            iirdf2t_pkg::REG_B2, iirdf2t_pkg::REG_B3:
                model_b[idx] = data[COEF_BITS-1:0];
            iirdf2t_pkg::REG_A1, iirdf2t_pkg::REG_A2, iirdf2t_pkg::REG_A3:
                model_a[idx - iirdf2t_pkg::REG_A1] = data[COEF_BITS-1:0];
            iirdf2t_pkg::REG_TAPS:
                model_taps = data[TAPS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // random filter, junk in the unused upper bits of every register
    task automatic program_random_filter();
        int unsigned style;
        logic [DATA_W-1:0] junk;
        style = $urandom_range(3);
        for (int r = 0; r < NUM_B + NUM_A; r++) begin
            junk = $urandom;
            reg_write(iirdf2t_pkg::reg_idx_t'(r),
                      {junk[DATA_W-1:COEF_BITS], pick_coef(style, r >= NUM_B)});
        end
        junk = $urandom;
        reg_write(iirdf2t_pkg::REG_TAPS, {junk[DATA_W-1:TAPS_W],
                                          TAPS_W'($urandom_range((1 << TAPS_W) - 1))});
    endtask

    // valid is only dropped during a gap, never between back-to-back words
    task automatic send_sample(input sample_t x, input bit fixed, input sample_t y,
                               input bit clip);
        preset_t pre;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        pre = '{fixed, '{y, clip}};
        preset_q.push_back(pre);
        s_valid     <= 1'b1;
        s_sample_in <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sequencer idle and every filtered word back
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (filtered_q.size() != 0 || !s_ready);
    endtask

    // result ready: random idling plus the occasional long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // check outgoing words first, then predict the word taken in this cycle
    always @(posedge aclk) begin : watch_ports
        filtered_t want;
        preset_t pre;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    note_mismatch("unexpected word", 0, longint'(m_filtered_out));
                end else begin
                    want = filtered_q.pop_front();
                    if (m_filtered_out !== want.y)
                        note_mismatch("filtered_out", want.y, longint'(m_filtered_out));
                    if (m_saturated_flag !== want.clip)
                        note_mismatch("saturated_flag", want.clip, longint'(m_saturated_flag));
                end
            end
            if (s_valid && s_ready) begin
                want = run_filter(s_sample_in);
                if (preset_q.size() != 0) begin
                    pre = preset_q.pop_front();
                    // hand-written rows override the model's answer
                    if (pre.fixed) want = pre.out;
                end
                filtered_q.push_back(want);
            end
        end
    end

    initial begin : run_stimulus
        int seg, k;
        model_b[0] = iirdf2t_pkg::B0_RESET;
        for (int i = 1; i < NUM_B; i++) model_b[i] = '0;
        for (int i = 0; i < NUM_A; i++) model_a[i] = '0;
        for (int i = 0; i < MAX_ORD; i++) model_z[i] = 0;
        model_taps = iirdf2t_pkg::TAPS_RESET;

        // reset values: unity gain, one tap
        plan_sample(0, 1'b1, 0, 1'b0);
        plan_sample(sample_t'(SAMPLE_MAX), 1'b1, sample_t'(SAMPLE_MAX), 1'b0);
        plan_sample(sample_t'(SAMPLE_MIN), 1'b1, sample_t'(SAMPLE_MIN), 1'b0);
        plan_sample(1, 1'b1, 1, 1'b0);
        plan_sample(-1, 1'b1, -1, 1'b0);
        // gain just under four: both ends clip, 4.5 minus a hair rounds to 4
        plan_write(iirdf2t_pkg::REG_B0, DATA_W'(COEF_MAX));
        plan_sample(sample_t'(SAMPLE_MAX), 1'b1, sample_t'(SAMPLE_MAX), 1'b1);
        plan_sample(sample_t'(SAMPLE_MIN), 1'b1, sample_t'(SAMPLE_MIN), 1'b1);
        plan_sample(1, 1'b1, 4, 1'b0);
        // gain of minus four: min times min overflows high, -3.5 rounds to -4
        plan_write(iirdf2t_pkg::REG_B0, DATA_W'(COEF_MIN));
        plan_sample(sample_t'(SAMPLE_MIN), 1'b1, sample_t'(SAMPLE_MAX), 1'b1);
        plan_sample(sample_t'(SAMPLE_MAX), 1'b1, sample_t'(SAMPLE_MIN), 1'b1);
        plan_sample(1, 1'b1, -4, 1'b0);
        plan_sample(0, 1'b1, 0, 1'b0);
        // zero taps acts as gain only
        plan_write(iirdf2t_pkg::REG_TAPS, '0);
        plan_sample(2, 1'b1, -8, 1'b0);
        // running sum of four words, tap count above the top clamps to four
        plan_write(iirdf2t_pkg::REG_B0, DATA_W'(COEF_ONE));
        plan_write(iirdf2t_pkg::REG_B1, DATA_W'(COEF_ONE));
        plan_write(iirdf2t_pkg::REG_B2, DATA_W'(COEF_ONE));
        plan_write(iirdf2t_pkg::REG_B3, DATA_W'(COEF_ONE));
        plan_write(iirdf2t_pkg::REG_A1, '0);
        plan_write(iirdf2t_pkg::REG_A2, '0);
        plan_write(iirdf2t_pkg::REG_A3, '0);
        plan_write(iirdf2t_pkg::REG_TAPS, DATA_W'(3'd7));
        plan_sample(100, 1'b0, '0, 1'b0);
        plan_sample(200, 1'b0, '0, 1'b0);
        plan_sample(300, 1'b0, '0, 1'b0);
        plan_sample(400, 1'b0, '0, 1'b0);
        plan_sample(-50, 1'b0, '0, 1'b0);
        // all coefficients at minus four: clipped y feeds back and the delays overflow
        plan_write(iirdf2t_pkg::REG_B0, DATA_W'(COEF_MIN));
        plan_write(iirdf2t_pkg::REG_B1, DATA_W'(COEF_MIN));
        plan_write(iirdf2t_pkg::REG_B2, DATA_W'(COEF_MIN));
        plan_write(iirdf2t_pkg::REG_B3, DATA_W'(COEF_MIN));
        plan_write(iirdf2t_pkg::REG_A1, DATA_W'(COEF_MIN));
        plan_write(iirdf2t_pkg::REG_A2, DATA_W'(COEF_MIN));
        plan_write(iirdf2t_pkg::REG_A3, DATA_W'(COEF_MIN));
        plan_write(iirdf2t_pkg::REG_TAPS, DATA_W'(3'd4));
        for (int i = 0; i < 4; i++) plan_sample(sample_t'(SAMPLE_MIN), 1'b0, '0, 1'b0);

        tx_idle_pct = 9;
        rx_idle_pct = 63;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows; registers only change with the filter drained
        foreach (plan_q[n]) begin
            if (plan_q[n].kind == ROW_WRITE) begin
                wait_idle();
                reg_write(plan_q[n].idx, plan_q[n].data);
            end else begin
                send_sample(plan_q[n].x, plan_q[n].fixed, plan_q[n].y, plan_q[n].clip);
            end
        end

        // random segments, a fresh filter each; idling swaps after four, none in the last four
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg / 4)
                0: begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 63;
                end
                1: begin
                    tx_idle_pct = 63;
                    rx_idle_pct = 9;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            wait_idle();
            program_random_filter();
            // long hold-off on the result side while words keep coming
            if (seg == 1 || seg == 9) holds_asked++;
            for (k = 0; k < SEGMENT_WORDS; k++) begin
                // sender stops until everything is back
                if (seg == 5 && k == SEGMENT_WORDS / 2) wait_idle();
                send_sample(pick_sample(), 1'b0, '0, 1'b0);
            end
        end

        wait_idle();
        // room for a stray extra word to show up
        repeat (SETTLE_CYCLES) @(posedge aclk);
        err_count += filtered_q.size();
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
